FILE: sv/trs_pkg.sv
package trs_pkg;

    // Sizing of the design.
    localparam int MAX_WINDOW = 256;
    localparam int PRICE_BITS = 32;

    // Field widths of the channels and the configuration port.
    localparam int CLOSE_IN_W = 32;
    localparam int QTY_W      = 24;
    localparam int RSI_W      = 14;
    localparam int TRADE_W    = 32;
    localparam int PERIOD_W   = 8;
    localparam int WINDOW_W   = 9;
    localparam int LEVEL_W    = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    // Derived internal widths.
    localparam int CLOSE_W = (PRICE_BITS < CLOSE_IN_W) ? PRICE_BITS : CLOSE_IN_W;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 2);
    localparam int ADDR_W  = $clog2(2 * MAX_WINDOW + 1);
    localparam int SUM_W   = CLOSE_W + PTR_W;
    localparam int REM_W   = SUM_W + 4;
    localparam int PROD_W  = CLOSE_W + WIN_W;

    // The RSI is produced as four decimal digits, each found in four binary steps.
    localparam int RSI_DIGITS  = 4;
    localparam int DIGIT_BITS  = 4;
    localparam int DIG_CNT_W   = $clog2(RSI_DIGITS);
    localparam int BIT_CNT_W   = $clog2(DIGIT_BITS);

    localparam logic [RSI_W-1:0]   RSI_FULL = RSI_W'(10000);
    localparam logic [QTY_W-1:0]   BUY_QTY  = QTY_W'(100);
    localparam logic [TRADE_W-1:0] TRADE_MAX = '1;

    // Register defaults.
    localparam logic [PERIOD_W-1:0] RSI_PERIOD_RST   = PERIOD_W'(14);
    localparam logic [WINDOW_W-1:0] TREND_WINDOW_RST = WINDOW_W'(50);
    localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RST   = LEVEL_W'(7000);
    localparam logic [LEVEL_W-1:0]  OVERSOLD_RST     = LEVEL_W'(3000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RSI_PERIOD,
        REG_TREND_WINDOW,
        REG_OVERBOUGHT,
        REG_OVERSOLD
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_BUY,
        ACT_SELL
    } action_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_WIN,
        OP_RD_PREV,
        OP_DIFF_NEW,
        OP_ADD_NEW,
        OP_DIFF_OLD,
        OP_ADD_OLD,
        OP_DIV_INIT,
        OP_MUL10,
        OP_DIV_STEP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic [BIT_CNT_W-1:0]   bit_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic loss_zero;
        logic hist_ready;
    } dp_status_t;

endpackage

FILE: sv/trs_if.sv
// Bar channel: one closing price and the held quantity per transfer.
interface trs_bar_if;
    import trs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLOSE_IN_W-1:0] close_price;
    logic [QTY_W-1:0]   position_qty;

    modport source (output valid, output close_price, output position_qty, input ready);
    modport sink   (input valid, input close_price, input position_qty, output ready);
endinterface

// Result channel: one signal record per bar.
interface trs_result_if;
    import trs_pkg::*;

    logic               valid;
    logic               ready;
    logic               history_ready;
    logic [1:0]         action;
    logic [QTY_W-1:0]   order_qty;
    logic [RSI_W-1:0]   rsi_value;
    logic               uptrend;
    logic [RSI_W-1:0]   rsi_minimum;
    logic [RSI_W-1:0]   rsi_maximum;
    logic [TRADE_W-1:0] trade_count;

    modport source (
        output valid, output history_ready, output action, output order_qty,
        output rsi_value, output uptrend, output rsi_minimum, output rsi_maximum,
        output trade_count, input ready
    );
    modport sink (
        input valid, input history_ready, input action, input order_qty,
        input rsi_value, input uptrend, input rsi_minimum, input rsi_maximum,
        input trade_count, output ready
    );
endinterface

FILE: sv/trs_ctrl.sv
module trs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output trs_pkg::dp_cmd_t    cmd,
    input  trs_pkg::dp_status_t status
);
    import trs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WIN,
        S_RD_PREV,
        S_DIFF_NEW,
        S_ADD_NEW,
        S_DIFF_OLD,
        S_ADD_OLD,
        S_DIV_INIT,
        S_MUL10,
        S_DIV_STEP,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [DIG_CNT_W-1:0] digit_reg, digit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    // The result register may be reloaded once it is empty or being emptied.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and the operation for the datapath.
    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        cmd.bit_sel    = bit_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_RD_WIN;
                end
            end
            S_RD_WIN:
            begin
                cmd.op     = OP_RD_WIN;
                state_next = S_RD_PREV;
            end
            S_RD_PREV:
            begin
                cmd.op     = OP_RD_PREV;
                state_next = S_DIFF_NEW;
            end
            S_DIFF_NEW:
            begin
                cmd.op     = OP_DIFF_NEW;
                state_next = S_ADD_NEW;
            end
            S_ADD_NEW:
            begin
                cmd.op     = OP_ADD_NEW;
                state_next = S_DIFF_OLD;
            end
            S_DIFF_OLD:
            begin
                cmd.op     = OP_DIFF_OLD;
                state_next = S_ADD_OLD;
            end
            S_ADD_OLD:
            begin
                cmd.op     = OP_ADD_OLD;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                digit_next = '0;
                // No division is needed without losses or without enough history.
                if (status.loss_zero || !status.hist_ready)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL10;
                end
            end
            S_MUL10:
            begin
                cmd.op     = OP_MUL10;
                bit_next   = BIT_CNT_W'(DIGIT_BITS - 1);
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op   = OP_DIV_STEP;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    digit_next = digit_reg + 1'b1;
                    if (digit_reg == DIG_CNT_W'(RSI_DIGITS - 1))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MUL10;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_reg       <= '0;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            digit_reg     <= digit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: sv/trs_datapath.sv
module trs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [trs_pkg::CLOSE_IN_W-1:0]      close_price,
    input  logic [trs_pkg::QTY_W-1:0]           position_qty,
    input  trs_pkg::dp_cmd_t                    cmd,
    output trs_pkg::dp_status_t                 status,
    output logic                                history_ready,
    output logic [1:0]                          action,
    output logic [trs_pkg::QTY_W-1:0]           order_qty,
    output logic [trs_pkg::RSI_W-1:0]           rsi_value,
    output logic                                uptrend,
    output logic [trs_pkg::RSI_W-1:0]           rsi_minimum,
    output logic [trs_pkg::RSI_W-1:0]           rsi_maximum,
    output logic [trs_pkg::TRADE_W-1:0]         trade_count
);
    import trs_pkg::*;

    // Configuration and history state.
    logic [PERIOD_W-1:0] rsi_period_reg, rsi_period_next;
    logic [WINDOW_W-1:0] trend_window_reg, trend_window_next;
    logic [LEVEL_W-1:0]  overbought_reg, overbought_next;
    logic [LEVEL_W-1:0]  oversold_reg, oversold_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    bars_reg, bars_next;
    logic [SUM_W-1:0]    wsum_reg, wsum_next;
    logic [SUM_W-1:0]    gain_reg, gain_next;
    logic [SUM_W-1:0]    loss_reg, loss_next;
    logic [RSI_W-1:0]    low_mark_reg, low_mark_next;
    logic [RSI_W-1:0]    high_mark_reg, high_mark_next;
    logic [TRADE_W-1:0]  trades_reg, trades_next;

    // Per-bar working registers.
    logic [CLOSE_W-1:0]  close_reg, close_next;
    logic [QTY_W-1:0]    pos_reg, pos_next;
    logic [CLOSE_W-1:0]  old0_reg, old0_next;
    logic [CLOSE_W-1:0]  mag_reg, mag_next;
    logic                gain_dir_reg, gain_dir_next;
    logic [SUM_W-1:0]    div_reg, div_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [RSI_W-1:0]    quot_reg, quot_next;
    logic                lz_reg, lz_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Result payload.
    logic                hist_out_reg, hist_out_next;
    action_t             act_out_reg, act_out_next;
    logic [QTY_W-1:0]    qty_out_reg, qty_out_next;
    logic [RSI_W-1:0]    rsi_out_reg, rsi_out_next;
    logic                up_out_reg, up_out_next;

    // Close ring with a registered read port.
    logic [CLOSE_W-1:0]  close_ring_mem [MAX_WINDOW];
    logic [CLOSE_W-1:0]  rd_data_reg;
    logic [PTR_W-1:0]    rd_addr;

    logic [31:0]         per_wide;
    logic [31:0]         win_wide;
    logic [WIN_W-1:0]    eff_per;
    logic [WIN_W-1:0]    eff_win;
    logic [WIN_W-1:0]    per_plus1;
    logic [WIN_W-1:0]    need;
    logic [WIN_W-1:0]    back;
    logic [ADDR_W-1:0]   addr_sum;
    logic                hist_ok;
    logic [CLOSE_W-1:0]  diff_from;
    logic [CLOSE_W-1:0]  diff_to;
    logic [REM_W-1:0]    trial;
    logic [RSI_W-1:0]    rsi_calc;
    logic                up_calc;
    logic                buy;
    logic                sell;

    // Window lengths clamped into the supported range.
    always_comb
    begin
        per_wide = 32'(rsi_period_reg);
        if (per_wide == 32'd0)
        begin
            per_wide = 32'd1;
        end
        if (per_wide > 32'(MAX_WINDOW - 1))
        begin
            per_wide = 32'(MAX_WINDOW - 1);
        end
        win_wide = 32'(trend_window_reg);
        if (win_wide == 32'd0)
        begin
            win_wide = 32'd1;
        end
        if (win_wide > 32'(MAX_WINDOW))
        begin
            win_wide = 32'(MAX_WINDOW);
        end
    end

    assign eff_per   = per_wide[WIN_W-1:0];
    assign eff_win   = win_wide[WIN_W-1:0];
    assign per_plus1 = eff_per + 1'b1;
    assign need      = (per_plus1 > eff_win) ? per_plus1 : eff_win;
    assign hist_ok   = (bars_reg >= CNT_W'(need));

    assign status.hist_ready = hist_ok;
    assign status.loss_zero  = (loss_reg == '0);

    // Ring slot that lies a given number of bars behind the write pointer.
    always_comb
    begin
        case (cmd.op)
            OP_RD_WIN:   back = eff_win;
            OP_RD_PREV:  back = WIN_W'(1);
            OP_DIFF_NEW: back = per_plus1;
            OP_ADD_NEW:  back = eff_per;
            default:     back = WIN_W'(1);
        endcase
        addr_sum = ADDR_W'(wp_reg) + ADDR_W'(MAX_WINDOW) - ADDR_W'(back);
        if (addr_sum >= ADDR_W'(MAX_WINDOW))
        begin
            addr_sum = addr_sum - ADDR_W'(MAX_WINDOW);
        end
    end

    assign rd_addr = addr_sum[PTR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ADD_OLD)
        begin
            close_ring_mem[wp_reg] <= close_reg;
        end
        rd_data_reg <= close_ring_mem[rd_addr];
    end

    // Operands of the close-to-close difference.
    assign diff_from = (cmd.op == OP_DIFF_OLD) ? old0_reg : rd_data_reg;
    assign diff_to   = (cmd.op == OP_DIFF_OLD) ? rd_data_reg : close_reg;

    // Divisor scaled to the current binary step of the digit.
    assign trial = REM_W'(div_reg) << cmd.bit_sel;

    // Order decision for the finished bar.
    assign rsi_calc = lz_reg ? RSI_FULL : quot_reg;
    assign up_calc  = (prod_reg > PROD_W'(wsum_reg));
    assign buy      = up_calc && (rsi_calc <= oversold_reg) && (pos_reg == '0);
    assign sell     = (pos_reg != '0) && (!up_calc || (rsi_calc >= overbought_reg));

    always_comb
    begin
        rsi_period_next   = rsi_period_reg;
        trend_window_next = trend_window_reg;
        overbought_next   = overbought_reg;
        oversold_next     = oversold_reg;
        wp_next           = wp_reg;
        bars_next         = bars_reg;
        wsum_next         = wsum_reg;
        gain_next         = gain_reg;
        loss_next         = loss_reg;
        low_mark_next     = low_mark_reg;
        high_mark_next    = high_mark_reg;
        trades_next       = trades_reg;
        close_next        = close_reg;
        pos_next          = pos_reg;
        old0_next         = old0_reg;
        mag_next          = mag_reg;
        gain_dir_next     = gain_dir_reg;
        div_next          = div_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        lz_next           = lz_reg;
        prod_next         = prod_reg;
        hist_out_next     = hist_out_reg;
        act_out_next      = act_out_reg;
        qty_out_next      = qty_out_reg;
        rsi_out_next      = rsi_out_reg;
        up_out_next       = up_out_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                close_next = close_price[CLOSE_W-1:0];
                pos_next   = position_qty;
            end
            OP_RD_WIN:
            begin
                wsum_next = wsum_reg + SUM_W'(close_reg);
            end
            OP_RD_PREV:
            begin
                // Oldest close leaves the moving-average window.
                if (bars_reg >= CNT_W'(eff_win))
                begin
                    wsum_next = wsum_reg - SUM_W'(rd_data_reg);
                end
            end
            OP_DIFF_NEW, OP_DIFF_OLD:
            begin
                gain_dir_next = (diff_to > diff_from);
                mag_next      = (diff_to > diff_from) ? (diff_to - diff_from)
                                                      : (diff_from - diff_to);
            end
            OP_ADD_NEW:
            begin
                old0_next = rd_data_reg;
                if (bars_reg >= CNT_W'(1))
                begin
                    if (gain_dir_reg)
                    begin
                        gain_next = gain_reg + SUM_W'(mag_reg);
                    end
                    else
                    begin
                        loss_next = loss_reg + SUM_W'(mag_reg);
                    end
                end
            end
            OP_ADD_OLD:
            begin
                // Oldest difference leaves the RSI window; the close is stored.
                if (bars_reg >= CNT_W'(per_plus1))
                begin
                    if (gain_dir_reg)
                    begin
                        gain_next = gain_reg - SUM_W'(mag_reg);
                    end
                    else
                    begin
                        loss_next = loss_reg - SUM_W'(mag_reg);
                    end
                end
                wp_next = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (bars_reg < CNT_W'(MAX_WINDOW + 1))
                begin
                    bars_next = bars_reg + 1'b1;
                end
            end
            OP_DIV_INIT:
            begin
                div_next  = gain_reg + loss_reg;
                rem_next  = REM_W'(gain_reg);
                quot_next = '0;
                lz_next   = (loss_reg == '0);
                prod_next = PROD_W'(close_reg) * PROD_W'(eff_win);
            end
            OP_MUL10:
            begin
                rem_next  = (rem_reg << 3) + (rem_reg << 1);
                quot_next = (quot_reg << 3) + (quot_reg << 1);
            end
            OP_DIV_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    quot_next = quot_reg + (RSI_W'(1) << cmd.bit_sel);
                end
            end
            OP_EMIT:
            begin
                hist_out_next = hist_ok;
                act_out_next  = ACT_HOLD;
                qty_out_next  = '0;
                rsi_out_next  = '0;
                up_out_next   = 1'b0;
                if (hist_ok)
                begin
                    rsi_out_next = rsi_calc;
                    up_out_next  = up_calc;
                    if (rsi_calc < low_mark_reg)
                    begin
                        low_mark_next = rsi_calc;
                    end
                    if (rsi_calc > high_mark_reg)
                    begin
                        high_mark_next = rsi_calc;
                    end
                    if (buy)
                    begin
                        act_out_next = ACT_BUY;
                        qty_out_next = BUY_QTY;
                    end
                    else if (sell)
                    begin
                        act_out_next = ACT_SELL;
                        qty_out_next = pos_reg;
                    end
                    if ((buy || sell) && (trades_reg != TRADE_MAX))
                    begin
                        trades_next = trades_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Register writes; a window change restarts the history.
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RSI_PERIOD:
                begin
                    rsi_period_next = cfg_data[PERIOD_W-1:0];
                    wp_next         = '0;
                    bars_next       = '0;
                    wsum_next       = '0;
                    gain_next       = '0;
                    loss_next       = '0;
                end
                REG_TREND_WINDOW:
                begin
                    trend_window_next = cfg_data[WINDOW_W-1:0];
                    wp_next           = '0;
                    bars_next         = '0;
                    wsum_next         = '0;
                    gain_next         = '0;
                    loss_next         = '0;
                end
                REG_OVERBOUGHT:
                begin
                    overbought_next = cfg_data[LEVEL_W-1:0];
                end
                REG_OVERSOLD:
                begin
                    oversold_next = cfg_data[LEVEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // State with a defined reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsi_period_reg   <= RSI_PERIOD_RST;
            trend_window_reg <= TREND_WINDOW_RST;
            overbought_reg   <= OVERBOUGHT_RST;
            oversold_reg     <= OVERSOLD_RST;
            wp_reg           <= '0;
            bars_reg         <= '0;
            wsum_reg         <= '0;
            gain_reg         <= '0;
            loss_reg         <= '0;
            low_mark_reg     <= RSI_FULL;
            high_mark_reg    <= '0;
            trades_reg       <= '0;
        end
        else
        begin
            rsi_period_reg   <= rsi_period_next;
            trend_window_reg <= trend_window_next;
            overbought_reg   <= overbought_next;
            oversold_reg     <= oversold_next;
            wp_reg           <= wp_next;
            bars_reg         <= bars_next;
            wsum_reg         <= wsum_next;
            gain_reg         <= gain_next;
            loss_reg         <= loss_next;
            low_mark_reg     <= low_mark_next;
            high_mark_reg    <= high_mark_next;
            trades_reg       <= trades_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        close_reg    <= close_next;
        pos_reg      <= pos_next;
        old0_reg     <= old0_next;
        mag_reg      <= mag_next;
        gain_dir_reg <= gain_dir_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        lz_reg       <= lz_next;
        prod_reg     <= prod_next;
        hist_out_reg <= hist_out_next;
        act_out_reg  <= act_out_next;
        qty_out_reg  <= qty_out_next;
        rsi_out_reg  <= rsi_out_next;
        up_out_reg   <= up_out_next;
    end

    assign history_ready = hist_out_reg;
    assign action        = act_out_reg;
    assign order_qty     = qty_out_reg;
    assign rsi_value     = rsi_out_reg;
    assign uptrend       = up_out_reg;
    assign rsi_minimum   = low_mark_reg;
    assign rsi_maximum   = high_mark_reg;
    assign trade_count   = trades_reg;

endmodule

FILE: sv/trend_rsi_signal_core.sv
// Channel   Direction  Contents
// bar       in         close_price, position_qty
// result    out        history_ready, action, order_qty, rsi_value, uptrend,
//                      rsi_minimum, rsi_maximum, trade_count
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// After its transfer a bar reads the ring, updates the sums and sets up the
// divide, which is skipped when there are no losses or too little history.
// The divide runs four decimal digits of four compare-subtract steps each, on
// one shared subtractor; the single ring port reads four old closes in turn.
// Reset sets the registers to their defaults and clears the history; no pass
// over the ring is made. A stalled result holds the controller before loading.
module trend_rsi_signal_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trs_pkg::CFG_DATA_W-1:0]  cfg_data,
    trs_bar_if.sink                         bar,
    trs_result_if.source                    result
);
    import trs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer for one bar.
    trs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bar.valid),
        .in_ready  (bar.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Sums, ring, divider and decision.
    trs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .close_price   (bar.close_price),
        .position_qty  (bar.position_qty),
        .cmd           (cmd),
        .status        (status),
        .history_ready (result.history_ready),
        .action        (result.action),
        .order_qty     (result.order_qty),
        .rsi_value     (result.rsi_value),
        .uptrend       (result.uptrend),
        .rsi_minimum   (result.rsi_minimum),
        .rsi_maximum   (result.rsi_maximum),
        .trade_count   (result.trade_count)
    );

    // Without enough history no order leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.history_ready |->
            result.action == ACT_HOLD && result.order_qty == '0)
        else $error("order issued without enough history");

    // A valid RSI lies between the running marks.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.history_ready |->
            result.rsi_minimum <= result.rsi_value && result.rsi_value <= result.rsi_maximum)
        else $error("RSI outside its running marks");

    // A buy is only made in an uptrend and for the fixed lot.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.action == ACT_BUY |->
            result.uptrend && result.order_qty == BUY_QTY)
        else $error("buy order without uptrend or with wrong lot");

    // No bar is taken while the sequencer is working on another.
    assert property (@(posedge clk) disable iff (!rst_n)
        bar.valid && bar.ready |=> !bar.ready)
        else $error("bar taken while busy");

endmodule
